@@ hdl/i2cmbe_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and constants for the I2C master bit engine: command codes,
// sequence lengths and the tick and result structures.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

	// Command codes, also used as the running operation of the sequencer.
	typedef enum logic [2:0] {
		OP_IDLE  = 3'd0,
		OP_INIT  = 3'd1,
		OP_START = 3'd2,
		OP_STOP  = 3'd3,
		OP_WRITE = 3'd4,
		OP_READ  = 3'd5
	} op_t;

	// Number of ticks of each sequence.
	localparam logic [4:0] LEN_START = 5'd1;
	localparam logic [4:0] LEN_STOP  = 5'd2;
	localparam logic [4:0] LEN_BYTE  = 5'd19;

	// Phase positions inside a byte sequence.
	localparam logic [4:0] PH_DATA_END = 5'd16;
	localparam logic [4:0] PH_ACK      = 5'd17;
	localparam logic [4:0] PH_RX_DONE  = 5'd15;
	localparam logic [4:0] PH_ACK_CLK  = 5'd18;

	localparam logic [7:0] BYTE_MSB = 8'h80;

	// One input tick.
	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] tx_byte;
		logic       nack_after_read;
		logic       sda_in;
	} item_t;

	// One result tick.
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic [7:0] rx_byte;
		logic       rx_valid;
		logic       ack_level;
		logic       ack_valid;
	} res_t;

endpackage

@@ hdl/i2cmbe_seq.sv @@
// ----------------------------------------------------------------------------
// i2cmbe_seq
// Line sequencer: holds the running operation, phase counter, shift byte and
// resting line levels, and works out the result of one tick combinationally.
// ----------------------------------------------------------------------------
module i2cmbe_seq
	import i2cmbe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  item_t item,
	output res_t  res
);

	op_t        op_q;
	logic [4:0] phase_q;
	logic [7:0] shift_q;
	logic       ack_q;
	logic       scl_hold_q;
	logic       sda_hold_q;
	logic       drive_hold_q;

	op_t        op_eff;
	logic [7:0] shift_eff;
	logic       ack_eff;
	logic       init_hit;
	logic [4:0] len;
	logic       last;
	logic [7:0] rx_shift;

	op_t        op_d;
	logic [4:0] phase_d;
	logic [7:0] shift_d;
	logic       scl_hold_d;
	logic       sda_hold_d;
	logic       drive_hold_d;

	logic       scl;
	logic       sda;
	logic       drv;

	// A new command is taken only while idle; its first tick is this one.
	always_comb begin
		op_eff    = op_q;
		shift_eff = shift_q;
		ack_eff   = ack_q;
		init_hit  = 1'b0;
		if (op_q == OP_IDLE) begin
			case (item.cmd)
				OP_INIT: begin
					init_hit = 1'b1;
				end
				OP_START, OP_STOP: begin
					op_eff = op_t'(item.cmd);
				end
				OP_WRITE: begin
					op_eff    = OP_WRITE;
					shift_eff = item.tx_byte;
				end
				OP_READ: begin
					op_eff    = OP_READ;
					shift_eff = '0;
					ack_eff   = item.nack_after_read;
				end
				default: begin
				end
			endcase
		end
	end

	// Length of the running sequence and end detection.
	always_comb begin
		case (op_eff)
			OP_START: len = LEN_START;
			OP_STOP:  len = LEN_STOP;
			default:  len = LEN_BYTE;
		endcase
	end

	wire [4:0] phase_eff = (op_q == OP_IDLE) ? 5'd0 : phase_q;

	assign last     = (phase_eff == len - 5'd1);
	assign rx_shift = {shift_eff[6:0], item.sda_in};

	// Next-state logic.
	always_comb begin
		op_d         = op_eff;
		phase_d      = phase_eff + 5'd1;
		shift_d      = shift_eff;
		scl_hold_d   = scl_hold_q;
		sda_hold_d   = sda_hold_q;
		drive_hold_d = drive_hold_q;
		if (init_hit) begin
			scl_hold_d   = 1'b0;
			sda_hold_d   = 1'b0;
			drive_hold_d = 1'b1;
		end
		case (op_eff)
			OP_WRITE: begin
				if (phase_eff < PH_DATA_END && phase_eff[0]) begin
					shift_d = {shift_eff[6:0], 1'b0};
				end
			end
			OP_READ: begin
				if (phase_eff < PH_ACK && phase_eff[0]) begin
					shift_d = rx_shift;
				end
			end
			default: begin
			end
		endcase
		if (op_eff != OP_IDLE && last) begin
			op_d    = OP_IDLE;
			phase_d = 5'd0;
			case (op_eff)
				OP_START: begin
					scl_hold_d = 1'b0; sda_hold_d = 1'b0; drive_hold_d = 1'b1;
				end
				OP_STOP: begin
					scl_hold_d = 1'b1; sda_hold_d = 1'b1; drive_hold_d = 1'b1;
				end
				OP_WRITE: begin
					scl_hold_d = 1'b0; sda_hold_d = 1'b1; drive_hold_d = 1'b0;
				end
				default: begin
					scl_hold_d = 1'b0; sda_hold_d = ack_eff; drive_hold_d = 1'b1;
				end
			endcase
		end
		if (op_eff == OP_IDLE) begin
			phase_d = 5'd0;
		end
	end

	// Output logic: line levels and sampled data for this tick.
	always_comb begin
		scl          = scl_hold_q;
		sda          = sda_hold_q;
		drv          = drive_hold_q;
		res          = '0;
		if (init_hit) begin
			scl = 1'b0;
			sda = 1'b0;
			drv = 1'b1;
		end
		case (op_eff)
			OP_START: begin
				scl = 1'b1; sda = 1'b1; drv = 1'b1;
			end
			OP_STOP: begin
				drv = 1'b1;
				scl = (phase_eff == 5'd0);
				sda = (phase_eff != 5'd0);
			end
			OP_WRITE: begin
				if (phase_eff < PH_DATA_END) begin
					drv = 1'b1;
					scl = phase_eff[0];
					sda = |(shift_eff & BYTE_MSB);
				end else begin
					drv = 1'b0;
					scl = (phase_eff == PH_ACK);
					if (phase_eff == PH_ACK) begin
						res.ack_level = item.sda_in;
						res.ack_valid = 1'b1;
					end
				end
			end
			OP_READ: begin
				if (phase_eff < PH_ACK) begin
					drv = 1'b0;
					scl = phase_eff[0];
					if (phase_eff == PH_RX_DONE) begin
						res.rx_byte  = rx_shift;
						res.rx_valid = 1'b1;
					end
				end else begin
					drv = 1'b1;
					sda = ack_eff;
					scl = (phase_eff == PH_ACK_CLK);
				end
			end
			default: begin
			end
		endcase
		res.busy_res  = (op_eff != OP_IDLE);
		res.scl_level = scl;
		res.sda_drive = drv;
		res.sda_level = drv ? sda : 1'b1;
	end

	// State registers, updated once per tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= OP_IDLE;
			phase_q      <= 5'd0;
			shift_q      <= 8'd0;
			ack_q        <= 1'b0;
			scl_hold_q   <= 1'b1;
			sda_hold_q   <= 1'b1;
			drive_hold_q <= 1'b0;
		end else if (step) begin
			op_q         <= op_d;
			phase_q      <= phase_d;
			shift_q      <= shift_d;
			ack_q        <= ack_eff;
			scl_hold_q   <= scl_hold_d;
			sda_hold_q   <= sda_hold_d;
			drive_hold_q <= drive_hold_d;
		end
	end

endmodule

@@ hdl/i2c_master_bit_engine_core.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// I2C master line sequencer: one input transaction per bus tick, one result
// transaction per tick with the SCL/SDA levels and sampled data.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------------------------
//   input   | in_valid  | in_stall  | cmd, tx_byte, nack_after_read, sda_in
//   output  | out_valid | out_stall | scl_level .. ack_valid
//
// One transaction is accepted per cycle while the output is not stalled; it passes
// the input register, then the sequencer logic into the result register.
// A stalled output freezes both stages, and in_stall follows it in the same
// cycle. arst_n clears valid flags and sequencer state (lines rest released).
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core
	import i2cmbe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] cmd,
	input  logic [7:0] tx_byte,
	input  logic       nack_after_read,
	input  logic       sda_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_level,
	output logic       sda_level,
	output logic       sda_drive,
	output logic       busy_res,
	output logic [7:0] rx_byte,
	output logic       rx_valid,
	output logic       ack_level,
	output logic       ack_valid
);

	logic  advance;
	logic  valid_s1;
	item_t item_s1;
	logic  valid_s2;
	res_t  res_s2;
	res_t  res_comb;

	// The pipeline moves unless a finished result is held by the receiver.
	assign advance  = !(valid_s2 && out_stall);
	assign in_stall = !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1 <= '{cmd: cmd, tx_byte: tx_byte,
				nack_after_read: nack_after_read, sda_in: sda_in};
		end
	end

	// Sequencer state and tick logic.
	i2cmbe_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.item   (item_s1),
		.res    (res_comb)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid = valid_s2;
	assign scl_level = res_s2.scl_level;
	assign sda_level = res_s2.sda_level;
	assign sda_drive = res_s2.sda_drive;
	assign busy_res  = res_s2.busy_res;
	assign rx_byte   = res_s2.rx_byte;
	assign rx_valid  = res_s2.rx_valid;
	assign ack_level = res_s2.ack_level;
	assign ack_valid = res_s2.ack_valid;

endmodule

@@ verif/i2c_master_bit_engine_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core_tb
// Self-checking bench for the I2C master bit engine. Ticks carrying commands
// and sampled SDA levels are fed in bursts, while the result side stalls on a
// pattern of its own and once holds off long enough to back up the input.
// A line sequencer model in the scoreboard predicts every result tick, and
// each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core_tb;
	import i2cmbe_pkg::*;

	// Codes outside the defined command set; the block must treat them as no command.
	localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
	localparam logic [2:0] CMD_UNDEF_HI = 3'd7;
	localparam int         RUN_TICKS    = 1850;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         DRAIN_CYCLES = 20;

	// Line sequencer model and the queue of line states it expects.
	class line_scoreboard;
		op_t        run_op;
		logic [4:0] phase;
		logic [7:0] shreg;
		logic       ack_sel;
		logic       scl_rest;
		logic       sda_rest;
		logic       drv_rest;
		res_t       expected_lines[$];
		int         mismatches;

		function new();
			run_op     = OP_IDLE;
			phase      = '0;
			shreg      = '0;
			ack_sel    = 1'b0;
			scl_rest   = 1'b1;
			sda_rest   = 1'b1;
			drv_rest   = 1'b0;
			mismatches = 0;
		endfunction

		function void set_rest(logic scl, logic sda, logic drv);
			scl_rest = scl;
			sda_rest = sda;
			drv_rest = drv;
		endfunction

		function int pending();
			return expected_lines.size();
		endfunction

		// Advance the model by one accepted tick and queue the line state it gives.
		function void note_tick(item_t it);
			res_t       r;
			logic [4:0] p;
			logic [4:0] len;
			r           = '0;
			len         = '0;
			r.scl_level = scl_rest;
			r.sda_level = sda_rest;
			r.sda_drive = drv_rest;

			// A command is taken only while no sequence is running.
			if (run_op == OP_IDLE) begin
				if (it.cmd == OP_INIT) begin
					set_rest(1'b0, 1'b0, 1'b1);
					r.scl_level = 1'b0;
					r.sda_level = 1'b0;
					r.sda_drive = 1'b1;
				end else if (it.cmd >= OP_START && it.cmd <= OP_READ) begin
					run_op = op_t'(it.cmd);
					phase  = '0;
					if (it.cmd == OP_WRITE)
						shreg = it.tx_byte;
					if (it.cmd == OP_READ) begin
						shreg   = '0;
						ack_sel = it.nack_after_read;
					end
				end
			end

			// Line levels of the running sequence at the current phase.
			if (run_op != OP_IDLE) begin
				r.busy_res = 1'b1;
				p = phase;
				case (run_op)
					OP_START: begin
						len         = LEN_START;
						r.scl_level = 1'b1;
						r.sda_level = 1'b1;
						r.sda_drive = 1'b1;
					end
					OP_STOP: begin
						len         = LEN_STOP;
						r.sda_drive = 1'b1;
						r.scl_level = (p == 5'd0);
						r.sda_level = (p != 5'd0);
					end
					OP_WRITE: begin
						len = LEN_BYTE;
						if (p < PH_DATA_END) begin
							r.sda_drive = 1'b1;
							r.scl_level = p[0];
							r.sda_level = ((shreg & BYTE_MSB) != 8'h00);
							if (p[0])
								shreg = shreg << 1;
						end else begin
							r.sda_drive = 1'b0;
							r.scl_level = (p == PH_ACK);
							if (p == PH_ACK) begin
								r.ack_level = it.sda_in;
								r.ack_valid = 1'b1;
							end
						end
					end
					default: begin
						len = LEN_BYTE;
						if (p < PH_ACK) begin
							r.sda_drive = 1'b0;
							r.scl_level = p[0];
							if (p[0]) begin
								shreg = {shreg[6:0], it.sda_in};
								if (p == PH_RX_DONE) begin
									r.rx_byte  = shreg;
									r.rx_valid = 1'b1;
								end
							end
						end else begin
							r.sda_drive = 1'b1;
							r.sda_level = ack_sel;
							r.scl_level = (p == PH_ACK_CLK);
						end
					end
				endcase

				// On the last tick the lines settle to the resting state of the sequence.
				if (p + 5'd1 >= len) begin
					case (run_op)
						OP_START: set_rest(1'b0, 1'b0, 1'b1);
						OP_STOP:  set_rest(1'b1, 1'b1, 1'b1);
						OP_WRITE: set_rest(1'b0, 1'b1, 1'b0);
						default:  set_rest(1'b0, ack_sel, 1'b1);
					endcase
					run_op = OP_IDLE;
					phase  = '0;
				end else begin
					phase = p + 5'd1;
				end
			end

			// A released data line reads as high.
			if (!r.sda_drive)
				r.sda_level = 1'b1;
			expected_lines.push_back(r);
		endfunction

		// Compare one result transaction with the oldest expected line state.
		function void check_tick(res_t got);
			res_t  want;
			string bad;
			bad = "";
			if (expected_lines.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result with nothing expected: %p", got);
				return;
			end
			want = expected_lines.pop_front();
			if (got.scl_level !== want.scl_level) bad = {bad, " scl_level"};
			if (got.sda_level !== want.sda_level) bad = {bad, " sda_level"};
			if (got.sda_drive !== want.sda_drive) bad = {bad, " sda_drive"};
			if (got.busy_res  !== want.busy_res)  bad = {bad, " busy_res"};
			if (got.rx_byte   !== want.rx_byte)   bad = {bad, " rx_byte"};
			if (got.rx_valid  !== want.rx_valid)  bad = {bad, " rx_valid"};
			if (got.ack_level !== want.ack_level) bad = {bad, " ack_level"};
			if (got.ack_valid !== want.ack_valid) bad = {bad, " ack_valid"};
			if (bad != "") begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: mismatch in%s: expected %p, got %p", bad, want, got);
			end
		endfunction
	endclass

	logic       clk             = 1'b0;
	logic       arst_n          = 1'b0;
	logic       in_valid        = 1'b0;
	logic       in_stall;
	logic [2:0] cmd             = '0;
	logic [7:0] tx_byte         = '0;
	logic       nack_after_read = 1'b0;
	logic       sda_in          = 1'b0;
	logic       out_valid;
	logic       out_stall       = 1'b0;
	logic       scl_level;
	logic       sda_level;
	logic       sda_drive;
	logic       busy_res;
	logic [7:0] rx_byte;
	logic       rx_valid;
	logic       ack_level;
	logic       ack_valid;

	line_scoreboard sb = new();
	int             tick_total = 0;
	int             burst_left = 0;

	i2c_master_bit_engine_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.tx_byte        (tx_byte),
		.nack_after_read(nack_after_read),
		.sda_in         (sda_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.scl_level      (scl_level),
		.sda_level      (sda_level),
		.sda_drive      (sda_drive),
		.busy_res       (busy_res),
		.rx_byte        (rx_byte),
		.rx_valid       (rx_valid),
		.ack_level      (ack_level),
		.ack_valid      (ack_valid)
	);

	// Clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// Offer one tick, with a random gap first when a burst has run out.
	task automatic send_tick(input logic [2:0] c, input logic [7:0] txb, input logic nk,
			input logic sd);
		item_t it;
		int    gap;
		it.cmd             = c;
		it.tx_byte         = txb;
		it.nack_after_read = nk;
		it.sda_in          = sd;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
				: $urandom_range(1, 30);
		end
		burst_left--;
		in_valid        <= 1'b1;
		cmd             <= c;
		tx_byte         <= txb;
		nack_after_read <= nk;
		sda_in          <= sd;
		do @(posedge clk); while (in_stall);
		sb.note_tick(it);
		tick_total++;
	endtask

	// Issue a command and fill its whole sequence with ticks. Read bits and the
	// write ack come from sda_pat; ticks inside the sequence may carry stray
	// commands, which the block must ignore.
	task automatic run_cmd(input logic [2:0] c, input logic [7:0] txb, input logic nk,
			input logic [7:0] sda_pat, input int noise_pct);
		int         n;
		logic [2:0] fc;
		logic       sd;
		n = 1;
		if (c == OP_START)
			n = int'(LEN_START);
		else if (c == OP_STOP)
			n = int'(LEN_STOP);
		else if (c == OP_WRITE || c == OP_READ)
			n = int'(LEN_BYTE);
		for (int k = 0; k < n; k++) begin
			if (k == 0)
				fc = c;
			else if ($urandom_range(0, 99) < noise_pct)
				fc = 3'($urandom_range(1, 7));
			else
				fc = OP_IDLE;
			sd = 1'($urandom);
			if (c == OP_READ && k[0] && k < int'(PH_DATA_END))
				sd = sda_pat[7 - k / 2];
			else if (c == OP_WRITE && k == int'(PH_ACK))
				sd = sda_pat[0];
			send_tick(fc, (k == 0) ? txb : 8'($urandom), (k == 0) ? nk : 1'($urandom), sd);
		end
	endtask

	// Result checker.
	always @(posedge clk) begin
		res_t got;
		got.scl_level = scl_level;
		got.sda_level = sda_level;
		got.sda_drive = sda_drive;
		got.busy_res  = busy_res;
		got.rx_byte   = rx_byte;
		got.rx_valid  = rx_valid;
		got.ack_level = ack_level;
		got.ack_valid = ack_valid;
		if (arst_n && out_valid && !out_stall)
			sb.check_tick(got);
	end

	// Receiver stall pattern, with one long hold-off that backs up the input.
	initial begin
		int rx_cycles;
		int mode;
		int seg;
		bit held;
		bit s;
		rx_cycles = 0;
		held      = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && rx_cycles > 300) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (500) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			seg  = $urandom_range(10, 80);
			repeat (seg) begin
				case (mode)
					0: s = 1'b0;
					1: s = ($urandom_range(0, 99) < 30);
					2: s = ($urandom_range(0, 99) < 70);
					default: s = (rx_cycles % 4 == 0);
				endcase
				out_stall <= s;
				@(posedge clk);
				rx_cycles++;
			end
		end
	end

	// Timeout.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	// Reset, stimulus and end of run.
	initial begin
		int sel;
		int nb;
		bit rd;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: resting lines, undefined codes, stop from released lines,
		// every command, byte extremes, ack and nack, stray commands while busy.
		run_cmd(OP_IDLE, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(CMD_UNDEF_LO, 8'hFF, 1'b1, 8'h00, 0);
		run_cmd(CMD_UNDEF_HI, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(OP_STOP, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(OP_INIT, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(OP_START, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(OP_WRITE, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(OP_WRITE, 8'hFF, 1'b1, 8'hFF, 100);
		run_cmd(OP_READ, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(OP_READ, 8'hFF, 1'b1, 8'hFF, 0);
		run_cmd(OP_READ, 8'h5A, 1'b1, 8'hA5, 50);
		run_cmd(OP_IDLE, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(OP_STOP, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(OP_IDLE, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(OP_START, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(OP_INIT, 8'h00, 1'b0, 8'h00, 0);
		run_cmd(OP_STOP, 8'h00, 1'b0, 8'h00, 0);

		// Random: mostly complete bus transfers, the rest single random commands.
		while (tick_total < RUN_TICKS) begin
			sel = $urandom_range(0, 99);
			if (sel < 80) begin
				if ($urandom_range(0, 3) == 0)
					run_cmd(OP_INIT, 8'($urandom), 1'($urandom), 8'($urandom), 5);
				run_cmd(OP_START, 8'($urandom), 1'($urandom), 8'($urandom), 5);
				run_cmd(OP_WRITE, 8'($urandom), 1'($urandom), 8'($urandom), 5);
				nb = $urandom_range(1, 3);
				rd = 1'($urandom);
				for (int j = 0; j < nb; j++) begin
					if (rd)
						run_cmd(OP_READ, 8'($urandom), (j == nb - 1), 8'($urandom), 5);
					else
						run_cmd(OP_WRITE, 8'($urandom), 1'($urandom), 8'($urandom), 5);
				end
				run_cmd(OP_STOP, 8'($urandom), 1'($urandom), 8'($urandom), 5);
				repeat ($urandom_range(0, 3))
					run_cmd(OP_IDLE, 8'($urandom), 1'($urandom), 8'($urandom), 0);
			end else begin
				run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
					8'($urandom), 20);
			end
		end
		in_valid <= 1'b0;

		// Drain, then give the block time to show any stray result.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
